// ===== rtl/ffc_pkg.sv =====
// Shared constants, types and codes for the five-field first-match classifier.
package ffc_pkg;

  localparam int RULE_DEPTH   = 1024;
  localparam int CELLS        = 8;
  localparam int ROWS         = RULE_DEPTH / CELLS;
  localparam int IDX_W        = $clog2(RULE_DEPTH);
  localparam int COUNT_W      = $clog2(RULE_DEPTH + 1);
  localparam int CELL_W       = $clog2(CELLS);
  localparam int ROW_W        = IDX_W - CELL_W;
  localparam int WORD_W       = 32;
  localparam int SPAN_W       = 16;
  localparam int MODE_W       = 2;
  localparam int RULE_INDEX_W = 10;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_CLEAR  = 2'd2
  } ffc_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_HOLD
  } ffc_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] w1_hi;
    logic [WORD_W-1:0] w1_lo;
    logic [WORD_W-1:0] w2_hi;
    logic [WORD_W-1:0] w2_lo;
    logic [SPAN_W-1:0] s1_hi;
    logic [SPAN_W-1:0] s1_lo;
    logic [SPAN_W-1:0] s2_hi;
    logic [SPAN_W-1:0] s2_lo;
    logic [SPAN_W-1:0] s3_hi;
    logic [SPAN_W-1:0] s3_lo;
  } ffc_rule_t;

  typedef struct packed {
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w2;
    logic [SPAN_W-1:0] s1;
    logic [SPAN_W-1:0] s2;
    logic [SPAN_W-1:0] s3;
  } ffc_key_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic             found;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] index;
  } ffc_token_t;

  typedef struct packed {
    logic             matched;
    logic [IDX_W-1:0] index;
    logic             full;
  } ffc_result_t;

endpackage

// ===== rtl/ffc_if.sv =====
// Request and response channel interfaces of the classifier.
interface ffc_req_if;
  logic                      valid;
  logic                      ready;
  logic [ffc_pkg::MODE_W-1:0] mode;
  logic [ffc_pkg::WORD_W-1:0] word_one_low_or_key;
  logic [ffc_pkg::WORD_W-1:0] word_one_high;
  logic [ffc_pkg::WORD_W-1:0] word_two_low_or_key;
  logic [ffc_pkg::WORD_W-1:0] word_two_high;
  logic [ffc_pkg::SPAN_W-1:0] span_one_low_or_key;
  logic [ffc_pkg::SPAN_W-1:0] span_one_high;
  logic [ffc_pkg::SPAN_W-1:0] span_two_low_or_key;
  logic [ffc_pkg::SPAN_W-1:0] span_two_high;
  logic [ffc_pkg::SPAN_W-1:0] span_three_low_or_key;
  logic [ffc_pkg::SPAN_W-1:0] span_three_high;

  modport source (
    output valid, mode, word_one_low_or_key, word_one_high, word_two_low_or_key,
           word_two_high, span_one_low_or_key, span_one_high, span_two_low_or_key,
           span_two_high, span_three_low_or_key, span_three_high,
    input  ready
  );

  modport sink (
    input  valid, mode, word_one_low_or_key, word_one_high, word_two_low_or_key,
           word_two_high, span_one_low_or_key, span_one_high, span_two_low_or_key,
           span_two_high, span_three_low_or_key, span_three_high,
    output ready
  );
endinterface

interface ffc_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             matched;
  logic [ffc_pkg::RULE_INDEX_W-1:0] rule_index;
  logic                             table_full;

  modport source (output valid, matched, rule_index, table_full, input ready);
  modport sink   (input valid, matched, rule_index, table_full, output ready);
endinterface

// ===== rtl/ffc_cell.sv =====
// One classifier cell: a slice of the rule table and a range compare on the passing token.
module ffc_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  ffc_pkg::ffc_token_t         tok_in,
  input  logic                        wr_en,
  input  logic [ffc_pkg::ROW_W-1:0]   wr_row,
  input  ffc_pkg::ffc_rule_t          wr_rule,
  input  ffc_pkg::ffc_key_t           key,
  input  logic [ffc_pkg::COUNT_W-1:0] rules_held,
  output ffc_pkg::ffc_token_t         tok_out
);

  ffc_pkg::ffc_rule_t  mem [ffc_pkg::ROWS];
  ffc_pkg::ffc_rule_t  rule_q;
  ffc_pkg::ffc_token_t tok;
  logic                in_range;
  logic                hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_rule;
    end
    rule_q <= mem[tok_in.pos[ffc_pkg::IDX_W-1:ffc_pkg::CELL_W]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      tok.valid <= tok_in.valid;
    end
    tok.last  <= tok_in.last;
    tok.found <= tok_in.found;
    tok.pos   <= tok_in.pos;
    tok.index <= tok_in.index;
  end

  always_comb begin
    in_range = (rule_q.w1_lo <= key.w1) && (key.w1 <= rule_q.w1_hi) &&
               (rule_q.w2_lo <= key.w2) && (key.w2 <= rule_q.w2_hi) &&
               (rule_q.s1_lo <= key.s1) && (key.s1 <= rule_q.s1_hi) &&
               (rule_q.s2_lo <= key.s2) && (key.s2 <= rule_q.s2_hi) &&
               (rule_q.s3_lo <= key.s3) && (key.s3 <= rule_q.s3_hi);
    hit = tok.valid && !tok.found && in_range &&
          (ffc_pkg::COUNT_W'(tok.pos) < rules_held);
    tok_out     = tok;
    tok_out.pos = tok.pos + ffc_pkg::IDX_W'(1);
    if (hit) begin
      tok_out.found = 1'b1;
      tok_out.index = tok.pos;
    end
  end

endmodule

// ===== rtl/five_field_first_match_classifier.sv =====
// Top level of the five-field first-match classifier: control, key register and cell chain.
//
// Rules live in a chain of eight cells; rule i sits in cell i mod 8 at row i / 8. An append,
// a clear or an unused mode is done as soon as it is accepted. A lookup sweeps one row of
// the chain per cycle, and its token then travels one cell per cycle to the end; an empty
// table answers at once. One transaction is worked on at a time; a finished result waits in
// the output register while the next request is taken, and a result that finds the output
// register still occupied waits in a holding register, which stalls requests until it moves
// on. The rule memories need no clearing pass after reset.
module five_field_first_match_classifier (
  input  logic  clk,
  input  logic  rst,
  ffc_req_if.sink   req,
  ffc_rsp_if.source rsp
);

  ffc_pkg::ffc_state_t  state;
  ffc_pkg::ffc_state_t  state_next;
  logic [ffc_pkg::COUNT_W-1:0] rules_held;
  logic [ffc_pkg::ROW_W-1:0]   inj_row;
  logic [ffc_pkg::ROW_W-1:0]   last_row;
  logic [ffc_pkg::IDX_W-1:0]   held_minus;
  ffc_pkg::ffc_key_t    key;
  ffc_pkg::ffc_rule_t   wr_rule;
  ffc_pkg::ffc_result_t pend;
  ffc_pkg::ffc_result_t done_res;
  ffc_pkg::ffc_token_t  head;
  ffc_pkg::ffc_token_t  chain [ffc_pkg::CELLS+1];
  ffc_pkg::ffc_token_t  end_tok;
  logic [ffc_pkg::CELLS-1:0]   wr_sel;
  logic                        got;
  logic [ffc_pkg::IDX_W-1:0]   got_index;
  logic                        out_valid;
  ffc_pkg::ffc_result_t        out_res;
  logic                        accept;
  logic                        done;
  logic                        out_free;
  logic                        is_full;
  logic                        append_write;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign is_full  = (rules_held == ffc_pkg::COUNT_W'(ffc_pkg::RULE_DEPTH));
  assign append_write = accept && (req.mode == ffc_pkg::MODE_APPEND) && !is_full;
  assign held_minus = ffc_pkg::IDX_W'(rules_held - ffc_pkg::COUNT_W'(1));
  assign last_row   = held_minus[ffc_pkg::IDX_W-1:ffc_pkg::CELL_W];
  assign end_tok    = chain[ffc_pkg::CELLS];
  assign chain[0]   = head;

  assign req.ready      = (state == ffc_pkg::ST_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.matched    = out_res.matched;
  assign rsp.rule_index = ffc_pkg::RULE_INDEX_W'(out_res.index);
  assign rsp.table_full = out_res.full;

  always_comb begin
    wr_rule.w1_lo = req.word_one_low_or_key;
    wr_rule.w1_hi = req.word_one_high;
    wr_rule.w2_lo = req.word_two_low_or_key;
    wr_rule.w2_hi = req.word_two_high;
    wr_rule.s1_lo = req.span_one_low_or_key;
    wr_rule.s1_hi = req.span_one_high;
    wr_rule.s2_lo = req.span_two_low_or_key;
    wr_rule.s2_hi = req.span_two_high;
    wr_rule.s3_lo = req.span_three_low_or_key;
    wr_rule.s3_hi = req.span_three_high;
    for (int i = 0; i < ffc_pkg::CELLS; i++) begin
      wr_sel[i] = append_write &&
                  (rules_held[ffc_pkg::CELL_W-1:0] == ffc_pkg::CELL_W'(i));
    end
  end

  always_comb begin
    head.valid = (state == ffc_pkg::ST_SWEEP);
    head.last  = (inj_row == last_row);
    head.found = 1'b0;
    head.pos   = {inj_row, {ffc_pkg::CELL_W{1'b0}}};
    head.index = '0;
  end

  for (genvar g = 0; g < ffc_pkg::CELLS; g++) begin : g_cell
    ffc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .tok_in     (chain[g]),
      .wr_en      (wr_sel[g]),
      .wr_row     (rules_held[ffc_pkg::IDX_W-1:ffc_pkg::CELL_W]),
      .wr_rule    (wr_rule),
      .key        (key),
      .rules_held (rules_held),
      .tok_out    (chain[g+1])
    );
  end

  always_comb begin
    done     = 1'b0;
    done_res = '0;
    case (state)
      ffc_pkg::ST_IDLE: begin
        if (accept) begin
          case (req.mode)
            ffc_pkg::MODE_APPEND: begin
              done          = 1'b1;
              done_res.full = is_full;
            end
            ffc_pkg::MODE_LOOKUP: begin
              done = (rules_held == '0);
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      ffc_pkg::ST_DRAIN: begin
        if (end_tok.valid && end_tok.last) begin
          done             = 1'b1;
          done_res.matched = got || end_tok.found;
          done_res.index   = got ? got_index : end_tok.index;
        end
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ffc_pkg::ST_IDLE: begin
        if (accept && (req.mode == ffc_pkg::MODE_LOOKUP) && (rules_held != '0)) begin
          state_next = ffc_pkg::ST_SWEEP;
        end else if (done && !out_free) begin
          state_next = ffc_pkg::ST_HOLD;
        end
      end
      ffc_pkg::ST_SWEEP: begin
        if (inj_row == last_row) begin
          state_next = ffc_pkg::ST_DRAIN;
        end
      end
      ffc_pkg::ST_DRAIN: begin
        if (done) begin
          state_next = out_free ? ffc_pkg::ST_IDLE : ffc_pkg::ST_HOLD;
        end
      end
      ffc_pkg::ST_HOLD: begin
        if (out_free) begin
          state_next = ffc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ffc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ffc_pkg::ST_IDLE;
      rules_held <= '0;
      out_valid  <= 1'b0;
      got        <= 1'b0;
      inj_row    <= '0;
    end else begin
      state <= state_next;
      if (append_write) begin
        rules_held <= rules_held + ffc_pkg::COUNT_W'(1);
      end else if (accept && (req.mode == ffc_pkg::MODE_CLEAR)) begin
        rules_held <= '0;
      end
      if (accept) begin
        inj_row <= '0;
        got     <= 1'b0;
      end else begin
        if (state == ffc_pkg::ST_SWEEP) begin
          inj_row <= inj_row + ffc_pkg::ROW_W'(1);
        end
        if (end_tok.valid && end_tok.found && !got) begin
          got <= 1'b1;
        end
      end
      if ((done || (state == ffc_pkg::ST_HOLD)) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req.mode == ffc_pkg::MODE_LOOKUP)) begin
      key.w1 <= req.word_one_low_or_key;
      key.w2 <= req.word_two_low_or_key;
      key.s1 <= req.span_one_low_or_key;
      key.s2 <= req.span_two_low_or_key;
      key.s3 <= req.span_three_low_or_key;
    end
    if (end_tok.valid && end_tok.found && !got) begin
      got_index <= end_tok.index;
    end
    if (done && !out_free) begin
      pend <= done_res;
    end
    if (done && out_free) begin
      out_res <= done_res;
    end else if ((state == ffc_pkg::ST_HOLD) && out_free) begin
      out_res <= pend;
    end
  end

  a_tokens_in_lookup: assert property (@(posedge clk) disable iff (rst)
    end_tok.valid |-> (state == ffc_pkg::ST_SWEEP) || (state == ffc_pkg::ST_DRAIN))
    else $error("lookup token left the chain outside a lookup");

  a_append_counts: assert property (@(posedge clk) disable iff (rst)
    append_write |=> rules_held == $past(rules_held) + ffc_pkg::COUNT_W'(1))
    else $error("append did not advance the rule count");

  a_hold_has_output: assert property (@(posedge clk) disable iff (rst)
    (state == ffc_pkg::ST_HOLD) |-> out_valid)
    else $error("result held while the output register is empty");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the five-field first-match classifier.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ffc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [WORD_W-1:0] WORD_TOP = '1;
  localparam logic [SPAN_W-1:0] SPAN_TOP = '1;
  localparam ffc_result_t NO_RESULT = '0;
  localparam ffc_result_t FIRST_RULE_HIT = '{matched: 1'b1, index: '0, full: 1'b0};
  localparam int RANDOM_PER_PHASE = 283;
  localparam int REPORT_LIMIT = 10;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    ffc_rule_t         bounds;
  } request_t;

  typedef struct packed {
    request_t    item;
    bit          fixed;
    ffc_result_t want;
  } directed_row_t;

  typedef struct packed {
    bit          fixed;
    ffc_result_t want;
  } pin_t;

  logic clk;
  logic rst;

  ffc_req_if req_ch ();
  ffc_rsp_if rsp_ch ();

  five_field_first_match_classifier DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ffc_rule_t   rule_table [RULE_DEPTH];
  int unsigned rules_stored = 0;
  ffc_rule_t   issued_rules [$];
  pin_t        pinned [$];
  ffc_result_t awaited_results [$];
  int          fault_count = 0;
  int          quiet_cycles = 0;
  int          src_idle_pct = 37;
  int          sink_idle_pct = 66;

  request_t    seen;
  pin_t        pin;
  ffc_result_t predicted;
  ffc_result_t got;
  ffc_result_t want;
  bit          progressed;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic ffc_result_t classify(input request_t item);
    ffc_result_t verdict;
    ffc_rule_t   r;
    int unsigned slot;
    verdict = '0;
    case (item.mode)
      MODE_APPEND: begin
        if (rules_stored < RULE_DEPTH) begin
          rule_table[rules_stored] = item.bounds;
          rules_stored++;
        end else begin
          verdict.full = 1'b1;
        end
      end
      MODE_LOOKUP: begin
        for (slot = 0; slot < rules_stored && !verdict.matched; slot++) begin
          r = rule_table[slot];
          if (r.w1_lo <= item.bounds.w1_lo && item.bounds.w1_lo <= r.w1_hi &&
              r.w2_lo <= item.bounds.w2_lo && item.bounds.w2_lo <= r.w2_hi &&
              r.s1_lo <= item.bounds.s1_lo && item.bounds.s1_lo <= r.s1_hi &&
              r.s2_lo <= item.bounds.s2_lo && item.bounds.s2_lo <= r.s2_hi &&
              r.s3_lo <= item.bounds.s3_lo && item.bounds.s3_lo <= r.s3_hi) begin
            verdict.matched = 1'b1;
            verdict.index = slot[IDX_W-1:0];
          end
        end
      end
      MODE_CLEAR: rules_stored = 0;
      default: ;
    endcase
    return verdict;
  endfunction

  function automatic ffc_rule_t rule_of(
    input logic [WORD_W-1:0] w1l, w1h, w2l, w2h,
    input logic [SPAN_W-1:0] s1l, s1h, s2l, s2h, s3l, s3h
  );
    ffc_rule_t r;
    r.w1_lo = w1l;
    r.w1_hi = w1h;
    r.w2_lo = w2l;
    r.w2_hi = w2h;
    r.s1_lo = s1l;
    r.s1_hi = s1h;
    r.s2_lo = s2l;
    r.s2_hi = s2h;
    r.s3_lo = s3l;
    r.s3_hi = s3h;
    return r;
  endfunction

  function automatic directed_row_t entry(
    input logic [MODE_W-1:0] mode,
    input ffc_rule_t         bounds,
    input bit                fixed,
    input ffc_result_t       want
  );
    directed_row_t row;
    row.item.mode = mode;
    row.item.bounds = bounds;
    row.fixed = fixed;
    row.want = want;
    return row;
  endfunction

  // Returns {hi, lo}: mostly ordered, sometimes full, point or inverted.
  function automatic logic [63:0] draw_bounds(input logic [WORD_W-1:0] top);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    a = $urandom & top;
    b = $urandom & top;
    case ($urandom_range(9))
      0: return {top, {WORD_W{1'b0}}};
      1: return {a, a};
      2: return (a > b) ? {b, a} : {a, b};
      default: return (a > b) ? {a, b} : {b, a};
    endcase
  endfunction

  function automatic ffc_rule_t draw_rule();
    ffc_rule_t   r;
    logic [63:0] b;
    b = draw_bounds(WORD_TOP);
    r.w1_hi = b[63:32];
    r.w1_lo = b[31:0];
    b = draw_bounds(WORD_TOP);
    r.w2_hi = b[63:32];
    r.w2_lo = b[31:0];
    b = draw_bounds(WORD_W'(SPAN_TOP));
    r.s1_hi = b[32 +: SPAN_W];
    r.s1_lo = b[SPAN_W-1:0];
    b = draw_bounds(WORD_W'(SPAN_TOP));
    r.s2_hi = b[32 +: SPAN_W];
    r.s2_lo = b[SPAN_W-1:0];
    b = draw_bounds(WORD_W'(SPAN_TOP));
    r.s3_hi = b[32 +: SPAN_W];
    r.s3_lo = b[SPAN_W-1:0];
    return r;
  endfunction

  // Mostly inside the bounds, at the edges often, just outside now and then.
  function automatic logic [WORD_W-1:0] aim_key(input logic [WORD_W-1:0] lo, hi);
    logic [63:0] width;
    width = {32'd0, hi} - {32'd0, lo} + 64'd1;
    case ($urandom_range(19))
      0: return lo - 1'b1;
      1: return hi + 1'b1;
      2, 3: return lo;
      4, 5: return hi;
      default: begin
        if (lo > hi) return lo;
        return lo + WORD_W'({32'd0, $urandom} % width);
      end
    endcase
  endfunction

  function automatic request_t aim_lookup();
    request_t  item;
    ffc_rule_t target;
    item.mode = MODE_LOOKUP;
    item.bounds = draw_rule();
    if (issued_rules.size() != 0 && $urandom_range(9) < 8) begin
      target = issued_rules[$urandom_range(issued_rules.size() - 1)];
      item.bounds.w1_lo = aim_key(target.w1_lo, target.w1_hi);
      item.bounds.w2_lo = aim_key(target.w2_lo, target.w2_hi);
      item.bounds.s1_lo = SPAN_W'(aim_key(WORD_W'(target.s1_lo), WORD_W'(target.s1_hi)));
      item.bounds.s2_lo = SPAN_W'(aim_key(WORD_W'(target.s2_lo), WORD_W'(target.s2_hi)));
      item.bounds.s3_lo = SPAN_W'(aim_key(WORD_W'(target.s3_lo), WORD_W'(target.s3_hi)));
    end
    return item;
  endfunction

  function automatic request_t draw_request();
    request_t    item;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 62) return aim_lookup();
    item.bounds = draw_rule();
    if (pick < 95) item.mode = MODE_APPEND;
    else if (pick < 99) item.mode = MODE_UNUSED;
    else item.mode = MODE_CLEAR;
    return item;
  endfunction

  task automatic present(input request_t item);
    req_ch.mode                  <= item.mode;
    req_ch.word_one_low_or_key   <= item.bounds.w1_lo;
    req_ch.word_one_high         <= item.bounds.w1_hi;
    req_ch.word_two_low_or_key   <= item.bounds.w2_lo;
    req_ch.word_two_high         <= item.bounds.w2_hi;
    req_ch.span_one_low_or_key   <= item.bounds.s1_lo;
    req_ch.span_one_high         <= item.bounds.s1_hi;
    req_ch.span_two_low_or_key   <= item.bounds.s2_lo;
    req_ch.span_two_high         <= item.bounds.s2_hi;
    req_ch.span_three_low_or_key <= item.bounds.s3_lo;
    req_ch.span_three_high       <= item.bounds.s3_hi;
  endtask

  task automatic offer_request(
    input request_t    item,
    input bit          fixed = 1'b0,
    input ffc_result_t want = NO_RESULT
  );
    pinned.push_back('{fixed: fixed, want: want});
    if (item.mode == MODE_APPEND && issued_rules.size() < RULE_DEPTH)
      issued_rules.push_back(item.bounds);
    else if (item.mode == MODE_CLEAR)
      issued_rules.delete();
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    present(item);
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic await_quiet();
    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0 || pinned.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    rsp_ch.ready <= !rst && ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      progressed = 1'b0;
      if (req_ch.valid && req_ch.ready) begin
        progressed = 1'b1;
        seen.mode = req_ch.mode;
        seen.bounds.w1_lo = req_ch.word_one_low_or_key;
        seen.bounds.w1_hi = req_ch.word_one_high;
        seen.bounds.w2_lo = req_ch.word_two_low_or_key;
        seen.bounds.w2_hi = req_ch.word_two_high;
        seen.bounds.s1_lo = req_ch.span_one_low_or_key;
        seen.bounds.s1_hi = req_ch.span_one_high;
        seen.bounds.s2_lo = req_ch.span_two_low_or_key;
        seen.bounds.s2_hi = req_ch.span_two_high;
        seen.bounds.s3_lo = req_ch.span_three_low_or_key;
        seen.bounds.s3_hi = req_ch.span_three_high;
        pin = pinned.pop_front();
        predicted = classify(seen);
        awaited_results.push_back(pin.fixed ? pin.want : predicted);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        progressed = 1'b1;
        got.matched = rsp_ch.matched;
        got.index = rsp_ch.rule_index;
        got.full = rsp_ch.table_full;
        if (awaited_results.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("%0t: result with none awaited: matched=%0b rule_index=%0d table_full=%0b",
                     $time, got.matched, got.index, got.full);
        end else begin
          want = awaited_results.pop_front();
          if (got.matched !== want.matched || got.index !== want.index ||
              got.full !== want.full) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
              $display("%0t: expected %0b/%0d/%0b got %0b/%0d/%0b (matched/rule_index/table_full)",
                       $time, want.matched, want.index, want.full,
                       got.matched, got.index, got.full);
          end
        end
      end
      quiet_cycles = progressed ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    directed_row_t directed_rows [$];
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    present('0);

    directed_rows.push_back(entry(MODE_LOOKUP,
      rule_of(WORD_TOP, '0, WORD_TOP, '0, SPAN_TOP, '0, SPAN_TOP, '0, SPAN_TOP, '0),
      1'b1, NO_RESULT));
    directed_rows.push_back(entry(MODE_UNUSED,
      rule_of(WORD_TOP, WORD_TOP, WORD_TOP, WORD_TOP, SPAN_TOP, SPAN_TOP,
              SPAN_TOP, SPAN_TOP, SPAN_TOP, SPAN_TOP), 1'b1, NO_RESULT));
    directed_rows.push_back(entry(MODE_LOOKUP, '0, 1'b1, NO_RESULT));
    directed_rows.push_back(entry(MODE_APPEND, '0, 1'b1, NO_RESULT));
    directed_rows.push_back(entry(MODE_APPEND,
      rule_of(32'd5, 32'd4, '0, WORD_TOP, '0, SPAN_TOP, '0, SPAN_TOP, '0, SPAN_TOP),
      1'b1, NO_RESULT));
    directed_rows.push_back(entry(MODE_APPEND,
      rule_of(WORD_TOP, WORD_TOP, WORD_TOP, WORD_TOP, SPAN_TOP, SPAN_TOP,
              SPAN_TOP, SPAN_TOP, SPAN_TOP, SPAN_TOP), 1'b1, NO_RESULT));
    directed_rows.push_back(entry(MODE_APPEND,
      rule_of('0, WORD_TOP, '0, WORD_TOP, '0, SPAN_TOP, '0, SPAN_TOP, 16'h8000, 16'h7FFF),
      1'b1, NO_RESULT));
    directed_rows.push_back(entry(MODE_APPEND,
      rule_of('0, WORD_TOP, WORD_TOP, '0, '0, SPAN_TOP, '0, SPAN_TOP, '0, SPAN_TOP),
      1'b1, NO_RESULT));
    directed_rows.push_back(entry(MODE_APPEND,
      rule_of('0, WORD_TOP, '0, WORD_TOP, SPAN_TOP, '0, '0, SPAN_TOP, '0, SPAN_TOP),
      1'b1, NO_RESULT));
    directed_rows.push_back(entry(MODE_APPEND,
      rule_of('0, WORD_TOP, '0, WORD_TOP, '0, SPAN_TOP, '0, SPAN_TOP, '0, SPAN_TOP),
      1'b1, NO_RESULT));
    directed_rows.push_back(entry(MODE_LOOKUP,
      rule_of('0, WORD_TOP, '0, WORD_TOP, '0, SPAN_TOP, '0, SPAN_TOP, '0, SPAN_TOP),
      1'b1, FIRST_RULE_HIT));
    directed_rows.push_back(entry(MODE_LOOKUP,
      rule_of(WORD_TOP, '0, WORD_TOP, '0, SPAN_TOP, '0, SPAN_TOP, '0, SPAN_TOP, '0),
      1'b0, NO_RESULT));
    directed_rows.push_back(entry(MODE_LOOKUP,
      rule_of(32'd4, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0, NO_RESULT));
    directed_rows.push_back(entry(MODE_LOOKUP,
      rule_of(32'd5, '0, '0, '0, '0, '0, '0, '0, 16'h7FFF, '0), 1'b0, NO_RESULT));
    directed_rows.push_back(entry(MODE_LOOKUP,
      rule_of(32'hA5A5_A5A5, WORD_TOP, 32'h5A5A_5A5A, WORD_TOP, 16'h8000, SPAN_TOP,
              16'h7FFF, SPAN_TOP, 16'h8000, SPAN_TOP), 1'b0, NO_RESULT));
    directed_rows.push_back(entry(MODE_LOOKUP,
      rule_of(32'd1, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0, NO_RESULT));
    directed_rows.push_back(entry(MODE_UNUSED,
      rule_of(32'h1234_5678, 32'h0, 32'h9ABC_DEF0, 32'h0, 16'h1357, 16'h0,
              16'h2468, 16'h0, 16'hFEDC, 16'h0), 1'b1, NO_RESULT));
    directed_rows.push_back(entry(MODE_LOOKUP,
      rule_of(WORD_TOP, WORD_TOP, WORD_TOP, WORD_TOP, SPAN_TOP, SPAN_TOP,
              SPAN_TOP, SPAN_TOP, SPAN_TOP, SPAN_TOP), 1'b0, NO_RESULT));
    directed_rows.push_back(entry(MODE_CLEAR, '1, 1'b1, NO_RESULT));
    directed_rows.push_back(entry(MODE_LOOKUP, '0, 1'b1, NO_RESULT));
    directed_rows.push_back(entry(MODE_APPEND,
      rule_of('0, WORD_TOP, '0, WORD_TOP, '0, SPAN_TOP, '0, SPAN_TOP, '0, SPAN_TOP),
      1'b1, NO_RESULT));
    directed_rows.push_back(entry(MODE_LOOKUP,
      rule_of(WORD_TOP, '0, WORD_TOP, '0, SPAN_TOP, '0, SPAN_TOP, '0, SPAN_TOP, '0),
      1'b1, FIRST_RULE_HIT));
    directed_rows.push_back(entry(MODE_CLEAR, '0, 1'b1, NO_RESULT));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_request(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
    await_quiet();

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 66 : 0;
      sink_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 37 : 0;
      repeat (RANDOM_PER_PHASE) offer_request(draw_request());
      await_quiet();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
